/* src/pipc_pkg.sv */
package pipc_pkg;

   localparam int INTEGRATOR_BITS_DEF = 32;
   localparam int ENCODER_BITS_DEF    = 16;

   localparam int Q_ONE       = 16384;
   localparam int GAIN_SHIFT  = 12;
   localparam int SCALE_SHIFT = 24;
   localparam int HI_SPLIT    = 16;

   // shared multiplier: signed A x signed B
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + HI_SPLIT;
   localparam int ERR_W   = 17;

   localparam int PADDR_W = 4;

   localparam logic [15:0] KP_GAIN_RST        = 16'd4096;
   localparam logic [15:0] KI_PER_TICK_RST    = 16'd0;
   localparam logic [31:0] POSITION_SCALE_RST = 32'd98170681;

   typedef enum logic [1:0] {
      REG_KP_GAIN        = 2'd0,
      REG_KI_PER_TICK    = 2'd1,
      REG_POSITION_SCALE = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      MUL_SCALE = 2'd0,
      MUL_PROP  = 2'd1,
      MUL_ILO   = 2'd2,
      MUL_IHI   = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD   = 2'd0,
      ACC_LOAD   = 2'd1,
      ACC_ADD    = 2'd2,
      ACC_ADD_HI = 2'd3
   } acc_op_type;

   typedef struct packed {
      logic signed [15:0] target_position;
      logic [15:0]        encoder_count;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               clamped;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] kp_gain;
      logic [15:0] ki_per_tick;
      logic [31:0] position_scale;
   } cfg_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        upd_err;
      acc_op_type  acc_op;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic target_ok;
   } status_type;

endpackage

/* src/pi_position_controller_core.sv */
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// request  | req_valid, req_stall, req_item          | in
// response | rsp_valid, rsp_stall, rsp_item          | out
// config   | psel, penable, pwrite, paddr, pwdata,   | in/out
//          | prdata, pready                          |
//
// An item is taken in idle and then runs through seven sequencer steps, four of
// them on the single shared 33x17 multiplier, and the result is registered in
// the last step. An item with a target beyond +-1.0 is dropped in idle with no
// result. Synchronous reset clears the sequencer, the result valid flag and the
// integrator, and loads register defaults. While an earlier result is still
// stalled, the sequencer waits in its last step. A new item is taken only once
// the sequencer is back in idle.
module pi_position_controller_core
   import pipc_pkg::*;
#(
   parameter int INTEGRATOR_BITS = INTEGRATOR_BITS_DEF,
   parameter int ENCODER_BITS    = ENCODER_BITS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type sts;

   pipc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pipc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pipc_dp #(
      .INTEGRATOR_BITS (INTEGRATOR_BITS),
      .ENCODER_BITS    (ENCODER_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .sts      (sts),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

/* src/pipc_regs.sv */
module pipc_regs
   import pipc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[PADDR_W-1:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_KP_GAIN:        cfg_in.kp_gain        = pwdata[15:0];
            REG_KI_PER_TICK:    cfg_in.ki_per_tick    = pwdata[15:0];
            REG_POSITION_SCALE: cfg_in.position_scale = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KP_GAIN:        prdata = {16'd0, cfg_ff.kp_gain};
         REG_KI_PER_TICK:    prdata = {16'd0, cfg_ff.ki_per_tick};
         REG_POSITION_SCALE: prdata = cfg_ff.position_scale;
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain        <= KP_GAIN_RST;
         cfg_ff.ki_per_tick    <= KI_PER_TICK_RST;
         cfg_ff.position_scale <= POSITION_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/pipc_dp.sv */
module pipc_dp
   import pipc_pkg::*;
#(
   parameter int INTEGRATOR_BITS = INTEGRATOR_BITS_DEF,
   parameter int ENCODER_BITS    = ENCODER_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   output status_type   sts,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int IB    = INTEGRATOR_BITS;
   localparam int CW    = (ENCODER_BITS < 16) ? ENCODER_BITS : 16;
   localparam int SH_W  = ACC_W - GAIN_SHIFT;
   localparam int HI_W  = IB - HI_SPLIT;

   logic signed [15:0]        target_ff;
   logic [CW-1:0]             count_ff;
   logic signed [ERR_W-1:0]   error_ff;
   logic signed [ERR_W-1:0]   error_in;
   logic signed [IB-1:0]      integral_ff;
   logic signed [IB-1:0]      integral_in;
   logic signed [IB:0]        isum;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [23:0]               scaled;
   logic [ERR_W-1:0]          scaled_sat;
   logic signed [ERR_W-1:0]   position;
   logic signed [SH_W-1:0]    acc_sh;
   rsp_item_type              rsp_ff;
   rsp_item_type              rsp_in;

   assign sts.target_ok = (req_item.target_position <= 16'(Q_ONE)) &&
                          (req_item.target_position >= -16'(Q_ONE));

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_SCALE: begin
            mul_a = {1'b0, cfg.position_scale};
            mul_b = {{(MUL_B_W-CW){1'b0}}, count_ff};
         end
         MUL_PROP: begin
            mul_a = {{(MUL_A_W-ERR_W){error_ff[ERR_W-1]}}, error_ff};
            mul_b = {1'b0, cfg.kp_gain};
         end
         MUL_ILO: begin
            mul_a = {{(MUL_A_W-HI_SPLIT){1'b0}}, integral_ff[HI_SPLIT-1:0]};
            mul_b = {1'b0, cfg.ki_per_tick};
         end
         default: begin
            mul_a = {{(MUL_A_W-HI_W){integral_ff[IB-1]}}, integral_ff[IB-1:HI_SPLIT]};
            mul_b = {1'b0, cfg.ki_per_tick};
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // encoder scaling, saturated at +1.0
   assign scaled     = prod_ff[SCALE_SHIFT+23:SCALE_SHIFT];
   assign scaled_sat = (scaled > 24'(2*Q_ONE)) ? ERR_W'(2*Q_ONE) : scaled[ERR_W-1:0];
   assign position   = scaled_sat - ERR_W'(Q_ONE);
   assign error_in   = {target_ff[15], target_ff} - position;

   assign isum = {integral_ff[IB-1], integral_ff} +
                 {{(IB+1-ERR_W){error_in[ERR_W-1]}}, error_in};

   always_comb begin
      if (isum[IB] != isum[IB-1]) begin
         integral_in = isum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
      end else begin
         integral_in = isum[IB-1:0];
      end
   end

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = prod_ext;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         ACC_ADD_HI: acc_in = acc_ff + {prod_ff[ACC_W-HI_SPLIT-1:0], {HI_SPLIT{1'b0}}};
         default:    acc_in = acc_ff;
      endcase
   end

   // floor shift by 12, then clamp to +-1.0
   assign acc_sh = acc_ff[ACC_W-1:GAIN_SHIFT];

   always_comb begin
      if (acc_sh > SH_W'(Q_ONE)) begin
         rsp_in.drive   = 16'(Q_ONE);
         rsp_in.clamped = 1'b1;
      end else if (acc_sh < -SH_W'(Q_ONE)) begin
         rsp_in.drive   = -16'(Q_ONE);
         rsp_in.clamped = 1'b1;
      end else begin
         rsp_in.drive   = acc_sh[15:0];
         rsp_in.clamped = 1'b0;
      end
   end

   assign rsp_item = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (cmd.upd_err) begin
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_ff <= req_item.target_position;
         count_ff  <= req_item.encoder_count[CW-1:0];
      end
      if (cmd.upd_err) begin
         error_ff <= error_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* src/pipc_ctrl.sv */
module pipc_ctrl
   import pipc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCALE = 8'b0000_0010,
      ST_ERR   = 8'b0000_0100,
      ST_PROP  = 8'b0000_1000,
      ST_ILO   = 8'b0001_0000,
      ST_IHI   = 8'b0010_0000,
      ST_SUMH  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_SCALE;
      cmd.acc_op   = ACC_HOLD;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            // out-of-range target: item dropped, no result
            if (accept && sts.target_ok) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCALE;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.upd_err = 1'b1;
            state_in    = ST_PROP;
         end
         ST_PROP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_ILO;
         end
         ST_ILO: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ILO;
            state_in    = ST_IHI;
         end
         ST_IHI: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_IHI;
            state_in    = ST_SUMH;
         end
         ST_SUMH: begin
            cmd.acc_op = ACC_ADD_HI;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* tb/sv/testbench.sv */
module testbench;
   import pipc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     Q_UNIT        = 16384;
   localparam longint INTEG_MAX     = 64'sd2147483647;
   localparam longint INTEG_MIN     = -INTEG_MAX - 1;
   localparam int     DRAIN_CYCLES  = 12;
   localparam int     CYCLE_LIMIT   = 3000000;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_TICKS   = 190;
   localparam int     WIND_TICKS    = 64;
   // register index 3 lies beyond the map: writes there must be dropped
   localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

   logic               clock   = 1'b0;
   logic               reset   = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_item_type       req_item = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_item_type       rsp_item;
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [31:0]        pwdata  = '0;
   logic [31:0]        prdata;
   logic               pready;

   // controller shadow
   bit [15:0]    kp_q    = KP_GAIN_RST;
   bit [15:0]    ki_q    = KI_PER_TICK_RST;
   bit [31:0]    scale_q = POSITION_SCALE_RST;
   longint       integ_model = 0;

   rsp_item_type pending_drives[$];

   bit  gaps_enable  = 1'b1;
   bit  stall_enable = 1'b1;
   int  hold_request = 0;

   int  fail_count = 0;
   int  ticks_sent = 0;
   int  ticks_rejected = 0;
   int  drives_checked = 0;
   int  drives_clamped = 0;
   int  integ_sat_hits = 0;
   int  settings_applied = 0;
   int  input_stall_cycles = 0;
   int  cycle_count = 0;

   pi_position_controller_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one control tick: returns 0 when the target is rejected
   function automatic bit predict_drive(input req_item_type it, output rsp_item_type res);
      longint    target;
      longint    position;
      longint    err;
      longint    acc;
      longint    level;
      bit [63:0] scaled;
      res    = '0;
      target = longint'($signed(it.target_position));
      if (target > Q_UNIT || target < -Q_UNIT)
         return 1'b0;
      scaled = (64'(it.encoder_count) * 64'(scale_q)) >> 24;
      if (scaled > 64'(2 * Q_UNIT))
         scaled = 64'(2 * Q_UNIT);
      position = longint'(scaled) - Q_UNIT;
      err = target - position;
      integ_model = integ_model + err;
      if (integ_model > INTEG_MAX) begin
         integ_model = INTEG_MAX;
         integ_sat_hits++;
      end else if (integ_model < INTEG_MIN) begin
         integ_model = INTEG_MIN;
         integ_sat_hits++;
      end
      acc   = longint'(kp_q) * err + longint'(ki_q) * integ_model;
      level = acc >>> 12;
      if (level > Q_UNIT) begin
         level = Q_UNIT;
         res.clamped = 1'b1;
      end else if (level < -Q_UNIT) begin
         level = -Q_UNIT;
         res.clamped = 1'b1;
      end
      res.drive = level[15:0];
      return 1'b1;
   endfunction

   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   function automatic req_item_type mk_tick(input int target, input int count);
      req_item_type it;
      it.target_position = 16'(target);
      it.encoder_count   = 16'(count);
      return it;
   endfunction

   function automatic req_item_type rand_tick();
      int unsigned r;
      int unsigned mag;
      int          t;
      int          c;
      r = $urandom_range(0, 99);
      if (r < 10)
         t = $urandom_range(0, 1) ? Q_UNIT : -Q_UNIT;
      else if (r < 25) begin
         // +32768 wraps to -32768, still out of range
         mag = $urandom_range(Q_UNIT + 1, 32768);
         t = $urandom_range(0, 1) ? -int'(mag) : int'(mag);
      end else
         t = int'($urandom_range(0, 2 * Q_UNIT)) - Q_UNIT;
      r = $urandom_range(0, 99);
      if (r < 10)
         c = 0;
      else if (r < 20)
         c = 16'hFFFF;
      else
         c = $urandom_range(0, 16'hFFFF);
      return mk_tick(t, c);
   endfunction

   function automatic logic [15:0] pick_gain(input int unsigned typical_max);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 16'd0;
      if (r < 30)
         return 16'hFFFF;
      if (r < 80)
         return 16'($urandom_range(0, typical_max));
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic [31:0] pick_scale();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return POSITION_SCALE_RST;
      if (r < 25)
         return 32'd0;
      if (r < 35)
         return 32'hFFFF_FFFF;
      if (r < 80)
         return $urandom_range(0, 32'h0100_0000);
      return $urandom();
   endfunction

   // result side: random stalls, plus a long hold when asked for
   initial begin : rsp_idler
      int left;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            left = hold_request;
            hold_request = 0;
         end else if (left == 0 && stall_enable)
            left = idle_len();
         rsp_stall <= (left > 0);
         if (left > 0)
            left--;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drives.size() == 0) begin
            $error("unexpected item: drive %0d clamped %0d", rsp_item.drive, rsp_item.clamped);
            fail_count++;
         end else begin
            want = pending_drives.pop_front();
            drives_checked++;
            if (want.clamped)
               drives_clamped++;
            if (rsp_item.drive !== want.drive) begin
               $error("drive: expected %0d, actual %0d", want.drive, rsp_item.drive);
               fail_count++;
            end
            if (rsp_item.clamped !== want.clamped) begin
               $error("clamped: expected %0d, actual %0d", want.clamped, rsp_item.clamped);
               fail_count++;
            end
         end
      end
   end

   task automatic send_tick(input req_item_type it);
      rsp_item_type res;
      int           gap;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
      if (predict_drive(it, res))
         pending_drives.push_back(res);
      else
         ticks_rejected++;
      gap = gaps_enable ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0)
         @(posedge clock);
      // a rejected tick may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic compare_reg(input reg_idx_type idx, input logic [31:0] want, input int bits);
      logic [31:0] rd;
      logic [31:0] mask;
      mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
      csr_read({idx, 2'b00}, rd);
      if ((rd & mask) !== (want & mask)) begin
         $error("%s readback: expected %0d, actual %0d", idx.name(), want & mask, rd & mask);
         fail_count++;
      end
   endtask

   task automatic check_registers();
      compare_reg(REG_KP_GAIN, {16'd0, kp_q}, 16);
      compare_reg(REG_KI_PER_TICK, {16'd0, ki_q}, 16);
      compare_reg(REG_POSITION_SCALE, scale_q, 32);
   endtask

   task automatic write_register(input reg_idx_type idx, input logic [31:0] value);
      csr_write({idx, 2'b00}, value);
      case (idx)
         REG_KP_GAIN:        kp_q    = value[15:0];
         REG_KI_PER_TICK:    ki_q    = value[15:0];
         REG_POSITION_SCALE: scale_q = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [31:0] scale);
      drain();
      // upper bits of the 16-bit registers are junk and must be masked off
      write_register(REG_KP_GAIN, {16'($urandom()), kp});
      write_register(REG_KI_PER_TICK, {16'($urandom()), ki});
      write_register(REG_POSITION_SCALE, scale);
      check_registers();
      settings_applied++;
   endtask

   task automatic test_directed();
      check_registers();
      send_tick(mk_tick(0, 0));               // drive lands exactly on +1.0
      send_tick(mk_tick(Q_UNIT, 0));          // full positive error
      send_tick(mk_tick(-Q_UNIT, 16'hFFFF));  // position saturates at +1.0
      send_tick(mk_tick(Q_UNIT + 1, 0));
      send_tick(mk_tick(-Q_UNIT - 1, 16'hFFFF));
      send_tick(mk_tick(32767, 1234));
      send_tick(mk_tick(-32768, 4321));
      send_tick(mk_tick(-Q_UNIT, 32768));
      send_tick(mk_tick(5000, 21845));
      configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_tick(mk_tick(Q_UNIT, 1));
      send_tick(mk_tick(-Q_UNIT, 1));
      send_tick(mk_tick(0, 16'h0101));
      send_tick(mk_tick(-1, 16'hFFFF));
      configure(16'd0, 16'd1, 32'd0);
      send_tick(mk_tick(Q_UNIT, 16'hFFFF));
      send_tick(mk_tick(-Q_UNIT, 0));
      send_tick(mk_tick(123, 16'hAAAA));
      drain();
      csr_write(UNMAPPED_ADDR, $urandom());
      check_registers();
      send_tick(mk_tick(-200, 16'h5555));
      send_tick(mk_tick(Q_UNIT, 16'h8000));
      configure(KP_GAIN_RST, KI_PER_TICK_RST, POSITION_SCALE_RST);
   endtask

   task automatic test_random_ticks();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure(pick_gain(8192), pick_gain(24), pick_scale());
         // one phase runs flat out on both sides
         stall_enable = (phase != 2);
         gaps_enable  = (phase != 2);
         repeat (PHASE_TICKS) send_tick(rand_tick());
      end
      stall_enable = 1'b1;
      gaps_enable  = 1'b1;
   endtask

   task automatic test_back_pressure();
      configure(pick_gain(8192), pick_gain(24), pick_scale());
      stall_enable = 1'b0;
      gaps_enable  = 1'b0;
      hold_request = 300;
      repeat (40) send_tick(rand_tick());
      stall_enable = 1'b1;
      gaps_enable  = 1'b1;
   endtask

   // wind the integrator hard negative with the gains off, then make it visible
   task automatic test_integrator_windup();
      configure(16'd0, 16'd0, POSITION_SCALE_RST);
      stall_enable = 1'b0;
      gaps_enable  = 1'b0;
      repeat (WIND_TICKS) send_tick(mk_tick(-Q_UNIT, 16'hFFFF));
      // large wound-up integral against full errors of both signs
      configure(16'hFFFF, 16'd1, POSITION_SCALE_RST);
      send_tick(mk_tick(-Q_UNIT, 16'hFFFF));
      repeat (3) send_tick(mk_tick(Q_UNIT, 0));
      stall_enable = 1'b1;
      gaps_enable  = 1'b1;
      repeat (40) send_tick(rand_tick());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_ticks();
      test_back_pressure();
      test_integrator_windup();
      drain();
      $display("Covered %0d ticks (%0d rejected targets), %0d drives checked, %0d clamped",
               ticks_sent, ticks_rejected, drives_checked, drives_clamped);
      $display("over %0d gain settings, %0d integrator limit hits, %0d input stall cycles",
               settings_applied, integ_sat_hits, input_stall_cycles);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
